// ===== hw/rtl/quaternion_to_euler_zyx_defines.svh =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ZYX_DEFINES_SVH
`define QUATERNION_TO_EULER_ZYX_DEFINES_SVH

// same-cycle implication
`define Q2E_ASSERT_SAME(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("q2e check failed");

// next-cycle implication
`define Q2E_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("q2e check failed");

`endif

// ===== hw/rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, constants and types of the quaternion to euler block
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

    localparam int PROD_W    = 32;  // 16x16 signed products
    localparam int TERM_W    = 36;  // q2.28 terms with headroom
    localparam int P_W       = 30;  // clamped asin argument
    localparam int PP_W      = 29;  // magnitude of clamped argument
    localparam int SQ_W      = 58;  // radicand and root workspace
    localparam int CV_W      = 38;  // cordic x and y
    localparam int ISQ_STEPS = 29;  // one cell per root bit
    localparam int ISQ_TOP   = 56;  // highest even bit of the radicand

    localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd268435456);
    localparam logic [SQ_W-1:0] ONE_Q56 = SQ_W'(1) << 56;

    localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // terms carried alongside the square root
    typedef struct packed {
        logic signed [TERM_W-1:0] sr;
        logic signed [TERM_W-1:0] cr;
        logic signed [TERM_W-1:0] sy;
        logic signed [TERM_W-1:0] cy;
        logic signed [P_W-1:0]    p;
        logic                     clamped;
    } fwd_t;

    // one cordic lane
    typedef struct packed {
        logic signed [CV_W-1:0] x;
        logic signed [CV_W-1:0] y;
        logic [31:0]            z;
        logic                   zero;
    } lane_t;

endpackage

`default_nettype wire

// ===== hw/rtl/q2e_front.sv =====
// ----------------------------------------------------------------------------
// q2e_front
// products, zyx terms, asin clamp and radicand, five pipeline stages
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [15:0]           in_w,
    input  logic signed [15:0]           in_x,
    input  logic signed [15:0]           in_y,
    input  logic signed [15:0]           in_z,
    output logic                         out_valid,
    output logic [q2e_pkg::SQ_W-1:0]     out_n,
    output q2e_pkg::fwd_t                out_fwd
);
    import q2e_pkg::*;

    logic [4:0] v_reg, v_next;

    logic signed [PROD_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] wz_reg, xy_reg, wy_reg, zx_reg;
    logic signed [PROD_W-1:0] wx_next, yz_next, xx_next, yy_next, zz_next;
    logic signed [PROD_W-1:0] wz_next, xy_next, wy_next, zx_next;

    logic signed [TERM_W-1:0] sr_reg, cr_reg, sy_reg, cy_reg, p_reg;
    logic signed [TERM_W-1:0] sr_next, cr_next, sy_next, cy_next, p_next;

    fwd_t            f3_reg, f3_next, f4_reg, f5_reg;
    logic [PP_W-1:0] pp_reg, pp_next;
    logic [SQ_W-1:0] sq_reg, sq_next, n_reg, n_next;

    always_comb
    begin
        v_next  = {v_reg[3:0], in_valid};
        wx_next = in_w * in_x;
        yz_next = in_y * in_z;
        xx_next = in_x * in_x;
        yy_next = in_y * in_y;
        zz_next = in_z * in_z;
        wz_next = in_w * in_z;
        xy_next = in_x * in_y;
        wy_next = in_w * in_y;
        zx_next = in_z * in_x;

        sr_next = (TERM_W'(wx_reg) + TERM_W'(yz_reg)) <<< 1;
        cr_next = ONE_Q28 - ((TERM_W'(xx_reg) + TERM_W'(yy_reg)) <<< 1);
        sy_next = (TERM_W'(wz_reg) + TERM_W'(xy_reg)) <<< 1;
        cy_next = ONE_Q28 - ((TERM_W'(yy_reg) + TERM_W'(zz_reg)) <<< 1);
        p_next  = (TERM_W'(wy_reg) - TERM_W'(zx_reg)) <<< 1;

        f3_next.sr = sr_reg;
        f3_next.cr = cr_reg;
        f3_next.sy = sy_reg;
        f3_next.cy = cy_reg;
        if (p_reg > ONE_Q28)
        begin
            f3_next.p       = P_W'(ONE_Q28);
            f3_next.clamped = 1'b1;
        end
        else if (p_reg < -ONE_Q28)
        begin
            f3_next.p       = P_W'(-ONE_Q28);
            f3_next.clamped = 1'b1;
        end
        else
        begin
            f3_next.p       = P_W'(p_reg);
            f3_next.clamped = 1'b0;
        end
        pp_next = f3_next.p[P_W-1] ? PP_W'(-f3_next.p) : PP_W'(f3_next.p);

        sq_next = SQ_W'(pp_reg) * SQ_W'(pp_reg);
        n_next  = ONE_Q56 - sq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= wx_next;
            yz_reg <= yz_next;
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
            wz_reg <= wz_next;
            xy_reg <= xy_next;
            wy_reg <= wy_next;
            zx_reg <= zx_next;
            sr_reg <= sr_next;
            cr_reg <= cr_next;
            sy_reg <= sy_next;
            cy_reg <= cy_next;
            p_reg  <= p_next;
            f3_reg <= f3_next;
            pp_reg <= pp_next;
            f4_reg <= f3_reg;
            sq_reg <= sq_next;
            f5_reg <= f4_reg;
            n_reg  <= n_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_n     = n_reg;
    assign out_fwd   = f5_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/q2e_isqrt_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_isqrt_cell
// one bit of the restoring integer square root, terms passed along
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_isqrt_cell #(
    parameter int BIT_POS = 56
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [q2e_pkg::SQ_W-1:0] in_n,
    input  logic [q2e_pkg::SQ_W-1:0] in_res,
    input  q2e_pkg::fwd_t            in_fwd,
    output logic                     out_valid,
    output logic [q2e_pkg::SQ_W-1:0] out_n,
    output logic [q2e_pkg::SQ_W-1:0] out_res,
    output q2e_pkg::fwd_t            out_fwd
);
    import q2e_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << BIT_POS;

    logic            v_reg;
    logic [SQ_W-1:0] n_reg, n_next, res_reg, res_next, trial;
    fwd_t            fwd_reg;

    always_comb
    begin
        trial = in_res + BIT;
        if (in_n >= trial)
        begin
            n_next   = in_n - trial;
            res_next = (in_res >> 1) + BIT;
        end
        else
        begin
            n_next   = in_n;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            res_reg <= res_next;
            fwd_reg <= in_fwd;
        end
    end

    assign out_valid = v_reg;
    assign out_n     = n_reg;
    assign out_res   = res_reg;
    assign out_fwd   = fwd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/q2e_cordic_pre.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_pre
// zero detect and quarter-turn pre-rotation into the right half plane
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_pre (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [q2e_pkg::TERM_W-1:0] in_y,
    input  logic signed [q2e_pkg::TERM_W-1:0] in_x,
    output q2e_pkg::lane_t                    out_lane
);
    import q2e_pkg::*;

    lane_t                  lane_reg, lane_next;
    logic signed [CV_W-1:0] xe, ye;

    always_comb
    begin
        xe = CV_W'(in_x);
        ye = CV_W'(in_y);
        lane_next.zero = (in_x == '0) && (in_y == '0);
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                lane_next.x = ye;
                lane_next.y = -xe;
                lane_next.z = QUARTER_TURN;
            end
            else
            begin
                lane_next.x = -ye;
                lane_next.y = xe;
                lane_next.z = THREE_QUARTER;
            end
        end
        else
        begin
            lane_next.x = xe;
            lane_next.y = ye;
            lane_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign out_lane = lane_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/q2e_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// one vectoring micro-rotation of a cordic lane
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic           clk,
    input  logic           en,
    input  q2e_pkg::lane_t in_lane,
    output q2e_pkg::lane_t out_lane
);
    import q2e_pkg::*;

    lane_t                  lane_reg, lane_next;
    logic signed [CV_W-1:0] xs, ys;

    always_comb
    begin
        xs = in_lane.x >>> SHIFT;
        ys = in_lane.y >>> SHIFT;
        lane_next.zero = in_lane.zero;
        if (in_lane.y > 0)
        begin
            lane_next.x = in_lane.x + ys;
            lane_next.y = in_lane.y - xs;
            lane_next.z = in_lane.z + ATAN_TAB[SHIFT];
        end
        else
        begin
            lane_next.x = in_lane.x - ys;
            lane_next.y = in_lane.y + xs;
            lane_next.z = in_lane.z - ATAN_TAB[SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign out_lane = lane_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_to_euler_zyx.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx
// attitude quaternion in q1.14 to zyx roll, pitch and yaw binary angles
// ----------------------------------------------------------------------------
// usage
//   s_* carries one quaternion request per accepted beat, m_* one result.
//   a request is taken when s_tvalid and s_tready are both high.
//   throughput: one request per cycle, sustained, with any m_tready pattern
//   that takes one result per cycle.
//   path: from acceptance to m_tvalid a request passes through five front
//   stages (products, terms, clamp, square, radicand), 29 square root cells,
//   one pre-rotation stage, the cordic cells and the output register.
//   stall: all stages advance together; an output register plus a skid
//   register catch the result in flight, so requests are still taken while
//   m_tready is low until the next result reaches the end of the chain,
//   then s_tready falls until the skid drains on the next taken result.
//   reset: rst_n clears all valid bits at once; no clearing pass, s_tready
//   is high right after reset.
//   pi shows as -32768; both atan2 operands zero give angle 0.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_zyx #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic        m_tuser    // pitch_clamped
);
    import q2e_pkg::*;

    // round half up from 32 bits down to ANGLE_BITS
    localparam int          SH      = 32 - ANGLE_BITS;
    localparam int          RND_POS = (SH > 0) ? SH - 1 : 0;
    localparam logic [31:0] RND     = (SH > 0) ? (32'(1) << RND_POS) : 32'd0;

    function automatic logic [15:0] to_angle(input lane_t ln);
        logic [31:0] zr;
        begin
            zr = (ln.zero ? 32'd0 : ln.z) + RND;
            to_angle = 16'(zr >> SH);
        end
    endfunction

    // global advance: stops only while the skid register is occupied
    logic en;

    // front
    logic            fr_valid;
    logic [SQ_W-1:0] fr_n;
    fwd_t            fr_fwd;

    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_w      (s_tdata[15:0]),
        .in_x      (s_tdata[31:16]),
        .in_y      (s_tdata[47:32]),
        .in_z      (s_tdata[63:48]),
        .out_valid (fr_valid),
        .out_n     (fr_n),
        .out_fwd   (fr_fwd)
    );

    // square root chain, one root bit per cell
    logic            isq_v   [0:ISQ_STEPS];
    logic [SQ_W-1:0] isq_n   [0:ISQ_STEPS];
    logic [SQ_W-1:0] isq_res [0:ISQ_STEPS];
    fwd_t            isq_fwd [0:ISQ_STEPS];

    assign isq_v[0]   = fr_valid;
    assign isq_n[0]   = fr_n;
    assign isq_res[0] = '0;
    assign isq_fwd[0] = fr_fwd;

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_isq
        q2e_isqrt_cell #(
            .BIT_POS (ISQ_TOP - 2 * k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (isq_v[k]),
            .in_n      (isq_n[k]),
            .in_res    (isq_res[k]),
            .in_fwd    (isq_fwd[k]),
            .out_valid (isq_v[k+1]),
            .out_n     (isq_n[k+1]),
            .out_res   (isq_res[k+1]),
            .out_fwd   (isq_fwd[k+1])
        );
    end

    fwd_t                     sq_fwd;
    logic signed [TERM_W-1:0] pitch_y, pitch_x;

    assign sq_fwd  = isq_fwd[ISQ_STEPS];
    assign pitch_y = TERM_W'(sq_fwd.p);
    assign pitch_x = TERM_W'(isq_res[ISQ_STEPS][PP_W-1:0]);

    // three cordic lanes: roll, pitch, yaw; index 0 is the pre-rotation
    lane_t roll_ln  [0:CORDIC_STAGES];
    lane_t pitch_ln [0:CORDIC_STAGES];
    lane_t yaw_ln   [0:CORDIC_STAGES];

    q2e_cordic_pre u_pre_roll (
        .clk (clk), .en (en), .in_y (sq_fwd.sr), .in_x (sq_fwd.cr),
        .out_lane (roll_ln[0])
    );
    q2e_cordic_pre u_pre_pitch (
        .clk (clk), .en (en), .in_y (pitch_y), .in_x (pitch_x),
        .out_lane (pitch_ln[0])
    );
    q2e_cordic_pre u_pre_yaw (
        .clk (clk), .en (en), .in_y (sq_fwd.sy), .in_x (sq_fwd.cy),
        .out_lane (yaw_ln[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        q2e_cordic_cell #(.SHIFT (i)) u_roll (
            .clk (clk), .en (en), .in_lane (roll_ln[i]), .out_lane (roll_ln[i+1])
        );
        q2e_cordic_cell #(.SHIFT (i)) u_pitch (
            .clk (clk), .en (en), .in_lane (pitch_ln[i]), .out_lane (pitch_ln[i+1])
        );
        q2e_cordic_cell #(.SHIFT (i)) u_yaw (
            .clk (clk), .en (en), .in_lane (yaw_ln[i]), .out_lane (yaw_ln[i+1])
        );
    end

    // valid and clamp flag ride beside the cordic cells
    logic [CORDIC_STAGES:0] cv_reg, cv_next;
    logic [CORDIC_STAGES:0] ccl_reg, ccl_next;

    assign cv_next  = {cv_reg[CORDIC_STAGES-1:0], isq_v[ISQ_STEPS]};
    assign ccl_next = {ccl_reg[CORDIC_STAGES-1:0], sq_fwd.clamped};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg <= '0;
        else if (en)
            cv_reg <= cv_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ccl_reg <= ccl_next;
    end

    // finished result of the chain
    logic        fin_valid;
    logic [47:0] fin_data;
    logic        fin_user;

    assign fin_valid = cv_reg[CORDIC_STAGES];
    assign fin_user  = ccl_reg[CORDIC_STAGES];
    assign fin_data  = {to_angle(yaw_ln[CORDIC_STAGES]),
                        to_angle(pitch_ln[CORDIC_STAGES]),
                        to_angle(roll_ln[CORDIC_STAGES])};

    // output register with skid
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg, out_data_next;
    logic        out_user_reg, out_user_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [47:0] skid_data_reg, skid_data_next;
    logic        skid_user_reg, skid_user_next;

    assign en = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;
        if (out_valid_reg && !m_tready)
        begin
            // receiver stalls: a result still in flight parks in the skid
            if (en && fin_valid)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = fin_data;
                skid_user_next  = fin_user;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            out_user_next   = skid_user_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = fin_valid;
            out_data_next  = fin_data;
            out_user_next  = fin_user;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/q2e_checker.sv =====
// ----------------------------------------------------------------------------
// q2e_checker
// port-level checks of the output stall and skid behavior
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_to_euler_zyx_defines.svh"

module q2e_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result stays put
    `Q2E_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `Q2E_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    // skid occupied only behind a waiting result
    `Q2E_ASSERT_SAME(a_skid_behind_out, !s_tready, m_tvalid)
    // one taken result drains the skid
    `Q2E_ASSERT_NEXT(a_skid_drains, !s_tready && m_tvalid && m_tready, s_tready && m_tvalid)

endmodule

bind quaternion_to_euler_zyx q2e_checker u_q2e_checker (.*);

`default_nettype wire
